// ===== design/rmc_pkg.sv =====
// ----------------------------------------------------------------------------
// rmc_pkg: shared definitions for the rotation matrix composer
// Request codes, sequencer states, pipeline tag type and sine table constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rmc_pkg;

  // Fixed geometry of the homogeneous transform
  localparam int unsigned MATRIX_DIM = 4;
  localparam int unsigned ELEMS      = MATRIX_DIM * MATRIX_DIM;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned REQ_W      = 2;
  localparam int unsigned ANGLE_W    = 8;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned PROD_W     = 2 * VAL_W;
  localparam int unsigned ACC_W      = PROD_W + 2;
  localparam int unsigned CNT_W      = 8;
  localparam int unsigned ROM_DEPTH  = 1 << ANGLE_W;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_ROTATE   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_IDENTITY = 2'd1;
  localparam logic [REQ_W-1:0] REQ_WRITE    = 2'd2;

  // Product order of a rotate: matrix * Ry, then * Rx, then * Rz
  localparam logic [1:0] PROD_Y = 2'd0;
  localparam logic [1:0] PROD_X = 2'd1;
  localparam logic [1:0] PROD_Z = 2'd2;

  // Last issue count: product Z, row 3, column 3, term 3
  localparam logic [CNT_W-1:0] CNT_LAST = {PROD_Z, 6'h3F};

  // Sine table arithmetic in Q2.30
  localparam longint unsigned Q30_ONE     = 64'd1073741824;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned SIN_DIV [7] = '{6, 20, 42, 72, 110, 156, 210};
  localparam longint unsigned COS_DIV [7] = '{2, 12, 30, 56, 90, 132, 182};

  typedef logic [PROD_W-1:0] sc_rom_t [ROM_DEPTH];

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic [IDX_W-1:0] dst;
    logic [1:0]       prod;
  } pipe_tag_t;

endpackage

// ===== design/rotation_matrix_composer.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_composer: 4x4 Euler rotation composer in signed fixed point
// Updates matrix = matrix * Ry * Rx * Rz on one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Flow: a rotate runs the multiply, drain and emit states before its elements leave;
//   load identity goes straight to emit. Requests are taken only in idle.
// Work: a rotate runs on the single MAC doing 3 products x 16 elements x 4 terms;
//   identity emits all 16 elements, and a write updates one element and stays idle.
// Reset: matrix returns to identity at once, no output item pending.
`timescale 1ns / 1ps

module rotation_matrix_composer #(
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned ANGLE_STEPS = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // request channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [rmc_pkg::REQ_W-1:0]       req_type_i,
  input  logic [rmc_pkg::ANGLE_W-1:0]     angle_x_i,
  input  logic [rmc_pkg::ANGLE_W-1:0]     angle_y_i,
  input  logic [rmc_pkg::ANGLE_W-1:0]     angle_z_i,
  input  logic [rmc_pkg::IDX_W-1:0]       elem_index_i,
  input  logic signed [rmc_pkg::VAL_W-1:0] elem_value_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [rmc_pkg::IDX_W-1:0]       out_index_o,
  output logic signed [rmc_pkg::VAL_W-1:0] out_value_o,
  output logic                            out_last_o,
  output logic                            saturated_o
);
  import rmc_pkg::*;

  // Q-format one on the diagonal
  localparam logic signed [VAL_W-1:0] ONE = VAL_W'(1) << FRAC_BITS;
  // Half an LSB of the result, for round half up
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (FRAC_BITS - 1);

  // --------------------------------------------------------------------------
  // Sine/cosine table, built at elaboration for every raw 8-bit angle.
  // Each entry packs {sin, cos} already mapped to its quadrant.
  // --------------------------------------------------------------------------
  function automatic longint unsigned to_frac(longint v);
    longint unsigned mag;
    int unsigned     sh;
    sh = 30 - FRAC_BITS;
    if (v < 0) begin
      v = 0;
    end
    if (v > longint'(Q30_ONE)) begin
      v = longint'(Q30_ONE);
    end
    mag = longint'(v);
    if (sh > 0) begin
      mag = (mag + (64'd1 << (sh - 1))) >> sh;
    end
    return mag;
  endfunction

  function automatic sc_rom_t build_rom();
    sc_rom_t                 rom;
    longint unsigned         p, q, r, x, x2, ts, tc, sv, cv;
    longint                  s, c;
    logic signed [VAL_W-1:0] so, co;
    for (int a = 0; a < ROM_DEPTH; a++) begin
      p  = longint'(a) % ANGLE_STEPS;
      q  = (4 * p) / ANGLE_STEPS;
      r  = (4 * p) % ANGLE_STEPS;
      x  = r * HALF_PI_Q30 / ANGLE_STEPS;
      x2 = (x * x) >> 30;
      ts = x;
      tc = Q30_ONE;
      s  = longint'(x);
      c  = longint'(Q30_ONE);
      for (int k = 0; k < 7; k++) begin
        ts = ((ts * x2) >> 30) / SIN_DIV[k];
        tc = ((tc * x2) >> 30) / COS_DIV[k];
        if ((k % 2) == 0) begin
          s = s - longint'(ts);
          c = c - longint'(tc);
        end else begin
          s = s + longint'(ts);
          c = c + longint'(tc);
        end
      end
      sv = to_frac(s);
      cv = to_frac(c);
      case (q[1:0])
        2'd0: begin
          so = VAL_W'(sv);
          co = VAL_W'(cv);
        end
        2'd1: begin
          so = VAL_W'(cv);
          co = VAL_W'(-longint'(sv));
        end
        2'd2: begin
          so = VAL_W'(-longint'(sv));
          co = VAL_W'(-longint'(cv));
        end
        default: begin
          so = VAL_W'(-longint'(cv));
          co = VAL_W'(sv);
        end
      endcase
      rom[a] = {so, co};
    end
    return rom;
  endfunction

  localparam sc_rom_t SC_ROM = build_rom();

  // Element e = {row, col} of the rotation used by product p
  function automatic logic signed [VAL_W-1:0] rot_elem(
    logic [1:0]              p,
    logic [IDX_W-1:0]        e,
    logic signed [VAL_W-1:0] s,
    logic signed [VAL_W-1:0] c
  );
    logic signed [VAL_W-1:0] v;
    v = (e[3:2] == e[1:0]) ? ONE : '0;
    unique case (p)
      PROD_Y: begin
        case (e)
          4'd0, 4'd10: v = c;
          4'd8:        v = s;
          4'd2:        v = -s;
          default:     v = v;
        endcase
      end
      PROD_X: begin
        case (e)
          4'd5, 4'd10: v = c;
          4'd6:        v = s;
          4'd9:        v = -s;
          default:     v = v;
        endcase
      end
      PROD_Z: begin
        case (e)
          4'd0, 4'd5: v = c;
          4'd1:       v = s;
          4'd4:       v = -s;
          default:    v = v;
        endcase
      end
      default: v = v;
    endcase
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  state_e                  state_q, state_d;
  logic [CNT_W-1:0]        cnt_q;        // issue count {prod, row, col, term}
  logic [IDX_W-1:0]        emit_idx_q;
  logic signed [VAL_W-1:0] t_q   [ELEMS]; // transform matrix
  logic signed [VAL_W-1:0] scr_mem [2*ELEMS]; // two scratch banks
  logic [ELEMS-1:0]        sat_q;
  logic signed [VAL_W-1:0] sin_q [3];    // indexed by product order
  logic signed [VAL_W-1:0] cos_q [3];

  // MAC pipeline
  logic signed [VAL_W-1:0]  a_q, r_q;
  logic signed [PROD_W-1:0] pp_q;
  logic signed [ACC_W-1:0]  acc_q;
  pipe_tag_t                s1_q, s2_q, s3_q, iss_tag;

  // Output register
  logic                    out_valid_q, out_last_q, out_sat_q;
  logic [IDX_W-1:0]        out_index_q;
  logic signed [VAL_W-1:0] out_value_q;

  logic                    in_accept, issue, out_load, pipe_empty;
  logic [1:0]              iss_p, iss_i, iss_j, iss_k;
  logic [IDX_W-1:0]        rd_addr;
  logic                    fin;
  logic signed [ACC_W-1:0] rnd, shv;
  logic                    ovf;
  logic signed [VAL_W-1:0] fin_val;

  assign {iss_p, iss_i, iss_j, iss_k} = cnt_q;
  assign pipe_empty = !s1_q.valid && !s2_q.valid && !s3_q.valid;
  assign out_load   = !out_valid_q || !out_stall_i;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d    = state_q;
    in_stall_o = (state_q != ST_IDLE);
    in_accept  = in_valid_i && (state_q == ST_IDLE);
    issue      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          priority if (req_type_i == REQ_ROTATE) begin
            state_d = ST_MUL;
          end else if (req_type_i == REQ_IDENTITY) begin
            state_d = ST_EMIT;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_MUL: begin
        issue = 1'b1;
        if (cnt_q == CNT_LAST) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (pipe_empty) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load && (emit_idx_q == IDX_W'(ELEMS - 1))) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Issue counter: restart on each accepted request, advance once per MAC term
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (in_accept) begin
      cnt_q <= '0;
    end else if (issue) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  // Latch sine and cosine of the three angles at acceptance
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      {sin_q[PROD_Y], cos_q[PROD_Y]} <= SC_ROM[angle_y_i];
      {sin_q[PROD_X], cos_q[PROD_X]} <= SC_ROM[angle_x_i];
      {sin_q[PROD_Z], cos_q[PROD_Z]} <= SC_ROM[angle_z_i];
    end
  end

  // --------------------------------------------------------------------------
  // Shared MAC: read operands, multiply, accumulate, round and saturate
  // --------------------------------------------------------------------------
  assign rd_addr = (state_q == ST_EMIT) ? emit_idx_q : {iss_i, iss_k};

  always_comb begin
    iss_tag       = '0;
    iss_tag.valid = issue;
    iss_tag.first = (iss_k == 2'd0);
    iss_tag.last  = (iss_k == 2'd3);
    iss_tag.dst   = {iss_i, iss_j};
    iss_tag.prod  = iss_p;
  end

  // Operand A: matrix for the first product, else the scratch bank just written
  always_ff @(posedge clk_i) begin
    if (iss_p == PROD_Y) begin
      a_q <= t_q[rd_addr];
    end else begin
      a_q <= scr_mem[{iss_p == PROD_Z, rd_addr}];
    end
    r_q  <= rot_elem(iss_p, {iss_k, iss_j}, sin_q[iss_p], cos_q[iss_p]);
    pp_q <= a_q * r_q;
    if (s2_q.first) begin
      acc_q <= {{(ACC_W-PROD_W){pp_q[PROD_W-1]}}, pp_q};
    end else begin
      acc_q <= acc_q + {{(ACC_W-PROD_W){pp_q[PROD_W-1]}}, pp_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
      s3_q <= '0;
    end else begin
      s1_q <= iss_tag;
      s2_q <= s1_q;
      s3_q <= s2_q;
    end
  end

  // Finalize one element in the cycle the accumulator holds its last term
  assign fin = s3_q.valid && s3_q.last;

  always_comb begin
    rnd     = acc_q + RND_HALF;
    shv     = rnd >>> FRAC_BITS;
    ovf     = !((&shv[ACC_W-1:VAL_W-1]) || !(|shv[ACC_W-1:VAL_W-1]));
    fin_val = shv[VAL_W-1:0];
    if (ovf) begin
      fin_val = shv[ACC_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end
  end

  // Scratch banks: the first product writes bank 0, the second bank 1
  always_ff @(posedge clk_i) begin
    if (fin && (s3_q.prod != PROD_Z)) begin
      scr_mem[{s3_q.prod == PROD_X, s3_q.dst}] <= fin_val;
    end
  end

  // Transform matrix
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int e = 0; e < ELEMS; e++) begin
        t_q[e] <= ((e % (MATRIX_DIM + 1)) == 0) ? ONE : '0;
      end
    end else if (in_accept && (req_type_i == REQ_IDENTITY)) begin
      for (int e = 0; e < ELEMS; e++) begin
        t_q[e] <= ((e % (MATRIX_DIM + 1)) == 0) ? ONE : '0;
      end
    end else if (in_accept && (req_type_i == REQ_WRITE)) begin
      t_q[elem_index_i] <= elem_value_i;
    end else if (fin && (s3_q.prod == PROD_Z)) begin
      t_q[s3_q.dst] <= fin_val;
    end
  end

  // Saturation flags: clear on rotate or identity, collect over all products
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q <= '0;
    end else if (in_accept &&
                 ((req_type_i == REQ_ROTATE) || (req_type_i == REQ_IDENTITY))) begin
      sat_q <= '0;
    end else if (fin && ovf) begin
      sat_q[s3_q.dst] <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Emit: load each element into the output register as the slot frees up
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_EMIT) && out_load) begin
      emit_idx_q  <= emit_idx_q + IDX_W'(1);
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_EMIT) && out_load) begin
      out_index_q <= emit_idx_q;
      out_value_q <= t_q[rd_addr];
      out_last_q  <= (emit_idx_q == IDX_W'(ELEMS - 1));
      out_sat_q   <= sat_q[emit_idx_q];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_index_o = out_index_q;
  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;
  assign saturated_o = out_sat_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Ready only with the MAC pipeline drained
  a_ready_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> pipe_empty)
    else $error("request taken while MAC pipeline busy");

  // Emission never overlaps MAC work
  a_emit_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> pipe_empty)
    else $error("emit started before pipeline drained");

  // The last flag comes with the final element index
  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_last_o) |-> (out_index_o == IDX_W'(ELEMS - 1)))
    else $error("last flag on wrong element");

endmodule

// ===== sim/rotation_matrix_composer_test.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_composer_test: self-checking bench for the matrix composer
// Feeds rotate, identity, element write and unknown requests with random
// handshake gaps. An in-bench model of the Q16.16 transform predicts every
// emitted element, which the result monitor checks field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rotation_matrix_composer_test;

  import rmc_pkg::*;

  // Fixed-point setup of the instance (default parameters)
  localparam int unsigned FRAC = 16;
  localparam int unsigned STEPS = 256;
  localparam longint unsigned SC_ONE = 64'd1073741824;       // 1.0 in Q2.30
  localparam longint unsigned SC_HALF_PI = 64'd1686629713;   // pi/2 in Q2.30

  // Request code the block has to ignore
  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

  localparam int RANDOM_ITEMS = 380;
  localparam int QUIET_LIMIT = 2500;   // cycles without any handshake
  localparam int DRAIN_CYCLES = 300;   // longer than one rotate pass
  localparam int REPORT_CAP = 40;

  typedef longint unsigned u64_t;
  typedef logic signed [VAL_W-1:0] elem_t;
  typedef logic [ELEMS-1:0][VAL_W-1:0] mat_t;

  typedef struct packed {
    logic [REQ_W-1:0]   req;
    logic [ANGLE_W-1:0] ax;
    logic [ANGLE_W-1:0] ay;
    logic [ANGLE_W-1:0] az;
    logic [IDX_W-1:0]   idx;
    logic [VAL_W-1:0]   val;
  } req_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] value;
    logic             last;
    logic             sat;
  } elem_result_t;

  // --------------------------------------------------------------------------
  // Clock, reset and block connections
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #1 clk = ~clk;

  logic in_valid = 1'b0;
  logic in_stall;
  req_item_t drv_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [IDX_W-1:0] out_index;
  logic signed [VAL_W-1:0] out_value;
  logic out_last;
  logic out_sat;

  rotation_matrix_composer i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .req_type_i   (drv_item.req),
    .angle_x_i    (drv_item.ax),
    .angle_y_i    (drv_item.ay),
    .angle_z_i    (drv_item.az),
    .elem_index_i (drv_item.idx),
    .elem_value_i (drv_item.val),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .out_index_o  (out_index),
    .out_value_o  (out_value),
    .out_last_o   (out_last),
    .saturated_o  (out_sat)
  );

  // --------------------------------------------------------------------------
  // Transform model: own copy of the matrix, updated per accepted request
  // --------------------------------------------------------------------------
  mat_t xform_model;
  req_item_t request_queue[$];
  elem_result_t elems_due[$];
  int err_count = 0;

  function automatic mat_t unit_matrix();
    mat_t m;
    for (int i = 0; i < ELEMS; i++) begin
      m[i] = (i % (MATRIX_DIM + 1) == 0) ? (32'd1 << FRAC) : 32'd0;
    end
    return m;
  endfunction

  // Clamp a Q2.30 series sum to [0, 1.0] and round it half up to FRAC bits.
  function automatic u64_t round_to_frac(longint sum);
    u64_t mag;
    if (sum < 0) sum = 0;
    if (sum > longint'(SC_ONE)) sum = longint'(SC_ONE);
    mag = u64_t'(sum);
    return (mag + (u64_t'(1) << (29 - FRAC))) >> (30 - FRAC);
  endfunction

  // Sine and cosine of one angle step: Taylor series over the first quadrant,
  // then fold into the quadrant the angle falls in.
  function automatic void sine_cosine(input logic [ANGLE_W-1:0] ang,
                                      output elem_t s_o, output elem_t c_o);
    u64_t p, q, r, x, x2, ts, tc, dv_s, dv_c;
    longint s, c;
    elem_t sv, cv;
    p = u64_t'(ang) % STEPS;
    q = (4 * p) / STEPS;
    r = (4 * p) % STEPS;
    x = r * SC_HALF_PI / STEPS;
    x2 = (x * x) >> 30;
    ts = x;
    tc = SC_ONE;
    s = longint'(x);
    c = longint'(SC_ONE);
    for (int k = 1; k <= 7; k++) begin
      dv_s = u64_t'((2 * k) * (2 * k + 1));
      dv_c = u64_t'((2 * k - 1) * (2 * k));
      ts = ((ts * x2) >> 30) / dv_s;
      tc = ((tc * x2) >> 30) / dv_c;
      if (k % 2 == 1) begin
        s -= longint'(ts);
        c -= longint'(tc);
      end else begin
        s += longint'(ts);
        c += longint'(tc);
      end
    end
    sv = elem_t'(round_to_frac(s));
    cv = elem_t'(round_to_frac(c));
    case (q[1:0])
      2'd0: begin s_o = sv;  c_o = cv;  end
      2'd1: begin s_o = cv;  c_o = -sv; end
      2'd2: begin s_o = -sv; c_o = -cv; end
      default: begin s_o = -cv; c_o = sv; end
    endcase
  endfunction

  // a * b with round half up and saturation; flag the saturated elements.
  function automatic mat_t mat_product(input mat_t a, input mat_t b,
                                       inout logic [ELEMS-1:0] sat);
    mat_t d;
    longint acc, v;
    for (int i = 0; i < MATRIX_DIM; i++) begin
      for (int j = 0; j < MATRIX_DIM; j++) begin
        acc = 0;
        for (int k = 0; k < MATRIX_DIM; k++) begin
          acc += longint'(elem_t'(a[i * MATRIX_DIM + k]))
               * longint'(elem_t'(b[k * MATRIX_DIM + j]));
        end
        v = (acc + (longint'(1) << (FRAC - 1))) >>> FRAC;
        if (v > 64'sd2147483647) begin
          v = 64'sd2147483647;
          sat[i * MATRIX_DIM + j] = 1'b1;
        end else if (v < -64'sd2147483648) begin
          v = -64'sd2147483648;
          sat[i * MATRIX_DIM + j] = 1'b1;
        end
        d[i * MATRIX_DIM + j] = v[VAL_W-1:0];
      end
    end
    return d;
  endfunction

  // Update the model for one accepted request and queue the elements it emits.
  function automatic void apply_request(req_item_t it);
    mat_t rx, ry, rz, part;
    logic [ELEMS-1:0] sat;
    elem_t s, c;
    bit emits;
    elem_result_t res;
    sat = '0;
    emits = 1'b0;
    case (it.req)
      REQ_ROTATE: begin
        rx = unit_matrix();
        ry = unit_matrix();
        rz = unit_matrix();
        sine_cosine(it.ax, s, c);
        rx[5] = c;  rx[6] = s;  rx[9] = -s;  rx[10] = c;
        sine_cosine(it.ay, s, c);
        ry[0] = c;  ry[8] = s;  ry[2] = -s;  ry[10] = c;
        sine_cosine(it.az, s, c);
        rz[0] = c;  rz[1] = s;  rz[4] = -s;  rz[5] = c;
        // Compose in the block's order: matrix * Ry, then * Rx, then * Rz
        part = mat_product(xform_model, ry, sat);
        part = mat_product(part, rx, sat);
        xform_model = mat_product(part, rz, sat);
        emits = 1'b1;
      end
      REQ_IDENTITY: begin
        xform_model = unit_matrix();
        emits = 1'b1;
      end
      REQ_WRITE: xform_model[it.idx] = it.val;
      default: ;  // unknown request: drop it, no state change
    endcase
    if (emits) begin
      for (int i = 0; i < ELEMS; i++) begin
        res.idx = IDX_W'(i);
        res.value = xform_model[i];
        res.last = (i == ELEMS - 1);
        res.sat = sat[i];
        elems_due.push_back(res);
      end
    end
  endfunction

  function automatic void check_field(string name, logic [VAL_W-1:0] want,
                                      logic [VAL_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%08h, got 0x%08h", name, want, got);
      err_count++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Handshake sampling, prediction and result checking at the rising edge
  // --------------------------------------------------------------------------
  logic req_taken = 1'b0;
  logic elem_taken = 1'b0;
  int quiet_cycles = 0;

  always @(posedge clk or negedge rst_n) begin
    elem_result_t want;
    if (!rst_n) begin
      xform_model <= unit_matrix();
      req_taken <= 1'b0;
      elem_taken <= 1'b0;
    end else begin
      req_taken <= in_valid && !in_stall;
      elem_taken <= out_valid && !out_stall;
      // Advance the model on every accepted request
      if (in_valid && !in_stall) apply_request(drv_item);
      // Check every accepted element against the oldest expectation
      if (out_valid && !out_stall) begin
        if (elems_due.size() == 0) begin
          if (err_count < REPORT_CAP)
            $error("unexpected element: index %0d value 0x%08h", out_index, out_value);
          err_count++;
        end else begin
          want = elems_due.pop_front();
          check_field("out_index", VAL_W'(want.idx), VAL_W'(out_index));
          check_field("out_value", want.value, out_value);
          check_field("out_last", VAL_W'(want.last), VAL_W'(out_last));
          check_field("saturated", VAL_W'(want.sat), VAL_W'(out_sat));
        end
      end
    end
  end

  // Watchdog: end the run once neither channel has moved for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("rotation_matrix_composer_test: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Request driver and result stall, both updated at the falling edge
  // --------------------------------------------------------------------------
  int req_gap = 0;
  int stall_left = 0;
  bit in_burst = 1'b0;
  bit out_burst = 1'b0;

  // Draw a hold-off; now and then switch into or out of a no-idle stretch.
  function automatic int hold_cycles(inout bit burst);
    if ($urandom_range(0, 19) == 0) burst = !burst;
    return burst ? 0 : int'($urandom_range(0, 11));
  endfunction

  always @(negedge clk) begin
    bit go;
    if (rst_n && (!in_valid || req_taken)) begin
      go = 1'b0;
      if (req_gap > 0) begin
        req_gap--;
      end else if (request_queue.size() > 0) begin
        drv_item <= request_queue.pop_front();
        go = 1'b1;
        req_gap = hold_cycles(in_burst);
      end
      in_valid <= go;
    end
  end

  // Hold stall for a drawn number of cycles per element, counted only while
  // an element is offered so that stalls land on the output phase.
  always @(negedge clk) begin
    if (rst_n) begin
      if (elem_taken) stall_left = hold_cycles(out_burst);
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        if (out_valid) stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  int items_made = 0;

  function automatic logic [ANGLE_W-1:0] pick_angle();
    logic [ANGLE_W-1:0] marks [8] = '{8'd0, 8'd32, 8'd64, 8'd96, 8'd128, 8'd192,
                                     8'd224, 8'd255};
    if ($urandom_range(0, 4) == 0) return marks[$urandom_range(0, 7)];
    return ANGLE_W'($urandom_range(0, 255));
  endfunction

  // Mix full-range values, extremes and modest Q16.16 values within +-4.0.
  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return VAL_W'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
    endcase
  endfunction

  // Queue one request; all fields random, kind fixed. Unknown kinds are noise.
  function automatic void push_random(logic [REQ_W-1:0] kind);
    req_item_t it;
    it.req = kind;
    it.ax = pick_angle();
    it.ay = pick_angle();
    it.az = pick_angle();
    it.idx = IDX_W'($urandom_range(0, ELEMS - 1));
    it.val = pick_value();
    request_queue.push_back(it);
    if (kind != REQ_UNKNOWN) items_made++;
  endfunction

  function automatic void push_fixed(logic [REQ_W-1:0] kind, logic [ANGLE_W-1:0] ax,
                                     logic [ANGLE_W-1:0] ay, logic [ANGLE_W-1:0] az,
                                     logic [IDX_W-1:0] idx, logic [VAL_W-1:0] val);
    request_queue.push_back('{req: kind, ax: ax, ay: ay, az: az, idx: idx, val: val});
  endfunction

  initial begin
    // Directed part: quadrant angles, extreme angles, extreme element values,
    // saturation on a rotate, an unknown request and exact pass-through.
    push_fixed(REQ_IDENTITY, 8'd0, 8'd0, 8'd0, 4'd0, 32'h0);
    push_fixed(REQ_ROTATE, 8'd0, 8'd0, 8'd0, 4'd15, 32'hFFFF_FFFF);
    push_fixed(REQ_ROTATE, 8'd64, 8'd0, 8'd0, 4'd0, 32'h0);
    push_fixed(REQ_ROTATE, 8'd0, 8'd128, 8'd0, 4'd0, 32'h0);
    push_fixed(REQ_ROTATE, 8'd0, 8'd0, 8'd192, 4'd0, 32'h0);
    push_fixed(REQ_ROTATE, 8'd255, 8'd255, 8'd255, 4'd0, 32'h0);
    push_fixed(REQ_ROTATE, 8'd1, 8'd2, 8'd3, 4'd0, 32'h0);
    push_fixed(REQ_UNKNOWN, 8'd255, 8'd255, 8'd255, 4'd15, 32'hFFFF_FFFF);
    push_fixed(REQ_WRITE, 8'd0, 8'd0, 8'd0, 4'd0, 32'h7FFF_FFFF);
    push_fixed(REQ_WRITE, 8'd0, 8'd0, 8'd0, 4'd1, 32'h7FFF_FFFF);
    push_fixed(REQ_WRITE, 8'd0, 8'd0, 8'd0, 4'd15, 32'h8000_0000);
    push_fixed(REQ_WRITE, 8'd0, 8'd0, 8'd0, 4'd4, 32'h8000_0000);
    push_fixed(REQ_ROTATE, 8'd32, 8'd32, 8'd32, 4'd0, 32'h0);
    push_fixed(REQ_IDENTITY, 8'd255, 8'd255, 8'd255, 4'd15, 32'hFFFF_FFFF);
    push_fixed(REQ_WRITE, 8'd0, 8'd0, 8'd0, 4'd3, 32'hFFFF_FFFF);
    push_fixed(REQ_WRITE, 8'd0, 8'd0, 8'd0, 4'd12, 32'h0000_0001);
    push_fixed(REQ_WRITE, 8'd0, 8'd0, 8'd0, 4'd7, 32'h8000_0000);
    push_fixed(REQ_ROTATE, 8'd0, 8'd0, 8'd0, 4'd0, 32'h0);
    push_fixed(REQ_ROTATE, 8'd16, 8'd224, 8'd96, 4'd0, 32'h0);
    push_fixed(REQ_IDENTITY, 8'd0, 8'd0, 8'd0, 4'd0, 32'h0);

    // Random part: mostly loads of a few elements followed by a rotate,
    // with lone identities, lone writes and unknown requests as noise.
    while (items_made < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          repeat ($urandom_range(0, 4)) push_random(REQ_WRITE);
          push_random(REQ_ROTATE);
        end
        6: push_random(REQ_IDENTITY);
        7: begin
          push_random(REQ_IDENTITY);
          push_random(REQ_ROTATE);
        end
        8: push_random(REQ_UNKNOWN);
        default: push_random(REQ_WRITE);
      endcase
    end

    // Hold reset, then release it away from the rising edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait until every request is taken and every element has come back
    while (request_queue.size() != 0 || in_valid || elems_due.size() != 0)
      @(negedge clk);
    // Let any stray element show up before the verdict
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (elems_due.size() != 0) begin
      $error("%0d elements still expected at the end", elems_due.size());
      err_count++;
    end

    if (err_count == 0) begin
      $display("rotation_matrix_composer_test: clean");
    end else begin
      $display("rotation_matrix_composer_test: errors");
    end
    $finish;
  end

endmodule
